[sv/pstd_pkg.sv]
// Shared types and constants for the packstream token decoder.
// Holds marker byte codes, token kinds, error codes, decoder phases and the result record.
// No dependencies.
package pstd_pkg;

    typedef enum logic [1:0] {
        PH_MARKER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_STRING  = 2'd2,
        PH_TAG     = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        K_NULL    = 4'd0,
        K_BOOL    = 4'd1,
        K_INT     = 4'd2,
        K_FLOAT   = 4'd3,
        K_STRHDR  = 4'd4,
        K_STRBYTE = 4'd5,
        K_LIST    = 4'd6,
        K_MAP     = 4'd7,
        K_STRUCT  = 4'd8,
        K_ERROR   = 4'd9
    } token_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_UNSUPPORTED = 2'd1,
        ERR_TOO_LARGE   = 2'd2,
        ERR_BAD_LENGTH  = 2'd3
    } error_code_t;

    localparam logic [7:0] M_NULL      = 8'hC0;
    localparam logic [7:0] M_FLOAT64   = 8'hC1;
    localparam logic [7:0] M_FALSE     = 8'hC2;
    localparam logic [7:0] M_TRUE      = 8'hC3;
    localparam logic [7:0] M_INT8      = 8'hC8;
    localparam logic [7:0] M_INT64     = 8'hCB;
    localparam logic [7:0] M_STR8      = 8'hD0;
    localparam logic [7:0] M_STR32     = 8'hD2;
    localparam logic [7:0] M_LIST8     = 8'hD4;
    localparam logic [7:0] M_LIST16    = 8'hD5;
    localparam logic [7:0] M_LIST32    = 8'hD6;
    localparam logic [7:0] M_MAP8      = 8'hD8;
    localparam logic [7:0] M_MAP16     = 8'hD9;
    localparam logic [7:0] M_MAP32     = 8'hDA;
    localparam logic [7:0] M_STRUCT8   = 8'hDC;
    localparam logic [7:0] M_STRUCT16  = 8'hDD;
    localparam logic [7:0] M_TINY_STR  = 8'h80;
    localparam logic [7:0] M_TINY_LIST = 8'h90;
    localparam logic [7:0] M_TINY_MAP  = 8'hA0;
    localparam logic [7:0] M_TINY_STRUCT = 8'hB0;
    localparam logic [7:0] M_NEG_TINY  = 8'hF0;

    typedef struct packed {
        token_kind_t kind;
        logic [63:0] value;
        logic [7:0]  tag;
        logic        ends;
        error_code_t err;
    } result_t;

endpackage

[sv/packstream_token_decoder.sv]
// Top level of the packstream token decoder: byte tokenizer with a two-entry output buffer.
// Depends on pstd_pkg for token kinds, error codes, marker codes and the result record.
// Single module; no submodules.

// One byte is taken per beat and decoded combinationally, so a stream runs at one byte
// per clock while in_stall is low; a completed token is registered in the result
// register, or in the skid register while the result register is held. Payload bytes of
// multi-byte integers, floats and string lengths produce no token until the last of them
// arrives. With the skid register, input is only stalled once two tokens wait downstream.
module packstream_token_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         in_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         token_kind,
    output logic signed [63:0] token_value,
    output logic signed [7:0]  struct_tag,
    output logic               ends_string,
    output logic [1:0]         error_code
);

    pstd_pkg::phase_t      phase_reg, phase_next;
    pstd_pkg::token_kind_t pending_kind_reg, pending_kind_next;
    logic [3:0]            payload_left_reg, payload_left_next;
    logic [63:0]           acc_reg, acc_next;
    logic [30:0]           string_left_reg, string_left_next;
    logic [3:0]            header_size_reg, header_size_next;

    pstd_pkg::result_t     res;
    logic                  res_valid;

    pstd_pkg::result_t     out_reg, skid_reg;
    logic                  out_valid_reg, skid_valid_reg;

    logic                  in_fire, out_fire, produce;
    logic [63:0]           shifted;
    logic [63:0]           ext;
    logic [3:0]            left_dec;
    logic [30:0]           str_dec;

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;
    assign produce  = in_fire && res_valid;

    assign shifted  = {acc_reg[55:0], in_byte};
    assign left_dec = (payload_left_reg != 4'd0) ? payload_left_reg - 4'd1 : 4'd0;
    assign str_dec  = (string_left_reg != 31'd0) ? string_left_reg - 31'd1 : 31'd0;

    always_comb
    begin
        unique case (header_size_reg)
            4'd1:    ext = {{56{shifted[7]}}, shifted[7:0]};
            4'd2:    ext = {{48{shifted[15]}}, shifted[15:0]};
            4'd3:    ext = {{40{shifted[23]}}, shifted[23:0]};
            4'd4:    ext = {{32{shifted[31]}}, shifted[31:0]};
            4'd5:    ext = {{24{shifted[39]}}, shifted[39:0]};
            4'd6:    ext = {{16{shifted[47]}}, shifted[47:0]};
            4'd7:    ext = {{8{shifted[55]}}, shifted[55:0]};
            default: ext = shifted;
        endcase
    end

    always_comb
    begin
        phase_next        = phase_reg;
        pending_kind_next = pending_kind_reg;
        payload_left_next = payload_left_reg;
        acc_next          = acc_reg;
        string_left_next  = string_left_reg;
        header_size_next  = header_size_reg;
        res_valid         = 1'b0;
        res.kind          = pstd_pkg::K_NULL;
        res.value         = 64'd0;
        res.tag           = 8'd0;
        res.ends          = 1'b0;
        res.err           = pstd_pkg::ERR_NONE;

        unique case (phase_reg)
            pstd_pkg::PH_PAYLOAD:
            begin
                acc_next          = shifted;
                payload_left_next = left_dec;
                if (left_dec == 4'd0)
                begin
                    phase_next = pstd_pkg::PH_MARKER;
                    res_valid  = 1'b1;
                    priority if (pending_kind_reg == pstd_pkg::K_INT)
                    begin
                        res.kind  = pstd_pkg::K_INT;
                        res.value = ext;
                    end
                    else if (pending_kind_reg == pstd_pkg::K_FLOAT)
                    begin
                        res.kind  = pstd_pkg::K_FLOAT;
                        res.value = shifted;
                    end
                    else if (shifted[31])
                    begin
                        res.kind  = pstd_pkg::K_ERROR;
                        res.value = {32'd0, shifted[31:0]};
                        res.err   = pstd_pkg::ERR_BAD_LENGTH;
                    end
                    else
                    begin
                        res.kind  = pstd_pkg::K_STRHDR;
                        res.value = {32'd0, shifted[31:0]};
                        if (shifted[30:0] == 31'd0)
                        begin
                            res.ends = 1'b1;
                        end
                        else
                        begin
                            phase_next       = pstd_pkg::PH_STRING;
                            string_left_next = shifted[30:0];
                        end
                    end
                end
            end
            pstd_pkg::PH_STRING:
            begin
                string_left_next = str_dec;
                res_valid        = 1'b1;
                res.kind         = pstd_pkg::K_STRBYTE;
                res.value        = {56'd0, in_byte};
                if (str_dec == 31'd0)
                begin
                    res.ends   = 1'b1;
                    phase_next = pstd_pkg::PH_MARKER;
                end
            end
            pstd_pkg::PH_TAG:
            begin
                phase_next = pstd_pkg::PH_MARKER;
                res_valid  = 1'b1;
                res.kind   = pstd_pkg::K_STRUCT;
                res.value  = {60'd0, header_size_reg};
                res.tag    = in_byte;
            end
            default:
            begin
                res_valid = 1'b1;
                priority if (!in_byte[7])
                begin
                    res.kind  = pstd_pkg::K_INT;
                    res.value = {56'd0, in_byte};
                end
                else if (in_byte >= pstd_pkg::M_NEG_TINY)
                begin
                    res.kind  = pstd_pkg::K_INT;
                    res.value = {56'hFF_FFFF_FFFF_FFFF, in_byte};
                end
                else if (in_byte >= pstd_pkg::M_INT8 && in_byte <= pstd_pkg::M_INT64)
                begin
                    res_valid         = 1'b0;
                    phase_next        = pstd_pkg::PH_PAYLOAD;
                    pending_kind_next = pstd_pkg::K_INT;
                    payload_left_next = 4'd1 << in_byte[1:0];
                    header_size_next  = 4'd1 << in_byte[1:0];
                    acc_next          = 64'd0;
                end
                else if (in_byte < pstd_pkg::M_TINY_LIST)
                begin
                    res.kind  = pstd_pkg::K_STRHDR;
                    res.value = {60'd0, in_byte[3:0]};
                    if (in_byte[3:0] == 4'd0)
                    begin
                        res.ends = 1'b1;
                    end
                    else
                    begin
                        phase_next       = pstd_pkg::PH_STRING;
                        string_left_next = {27'd0, in_byte[3:0]};
                    end
                end
                else if (in_byte < pstd_pkg::M_TINY_MAP)
                begin
                    res.kind  = pstd_pkg::K_LIST;
                    res.value = {60'd0, in_byte[3:0]};
                end
                else if (in_byte < pstd_pkg::M_TINY_STRUCT)
                begin
                    res.kind  = pstd_pkg::K_MAP;
                    res.value = {60'd0, in_byte[3:0]};
                end
                else if (in_byte < pstd_pkg::M_NULL)
                begin
                    res_valid        = 1'b0;
                    phase_next       = pstd_pkg::PH_TAG;
                    header_size_next = in_byte[3:0];
                end
                else if (in_byte >= pstd_pkg::M_STR8 && in_byte <= pstd_pkg::M_STR32)
                begin
                    res_valid         = 1'b0;
                    phase_next        = pstd_pkg::PH_PAYLOAD;
                    pending_kind_next = pstd_pkg::K_STRHDR;
                    payload_left_next = 4'd1 << in_byte[1:0];
                    header_size_next  = 4'd1 << in_byte[1:0];
                    acc_next          = 64'd0;
                end
                else if (in_byte == pstd_pkg::M_NULL)
                begin
                    res.kind = pstd_pkg::K_NULL;
                end
                else if (in_byte == pstd_pkg::M_FLOAT64)
                begin
                    res_valid         = 1'b0;
                    phase_next        = pstd_pkg::PH_PAYLOAD;
                    pending_kind_next = pstd_pkg::K_FLOAT;
                    payload_left_next = 4'd8;
                    header_size_next  = 4'd8;
                    acc_next          = 64'd0;
                end
                else if (in_byte == pstd_pkg::M_FALSE)
                begin
                    res.kind = pstd_pkg::K_BOOL;
                end
                else if (in_byte == pstd_pkg::M_TRUE)
                begin
                    res.kind  = pstd_pkg::K_BOOL;
                    res.value = 64'd1;
                end
                else if (in_byte == pstd_pkg::M_LIST8 || in_byte == pstd_pkg::M_LIST16
                         || in_byte == pstd_pkg::M_LIST32 || in_byte == pstd_pkg::M_MAP8
                         || in_byte == pstd_pkg::M_MAP16 || in_byte == pstd_pkg::M_MAP32
                         || in_byte == pstd_pkg::M_STRUCT8
                         || in_byte == pstd_pkg::M_STRUCT16)
                begin
                    res.kind  = pstd_pkg::K_ERROR;
                    res.value = {56'd0, in_byte};
                    res.err   = pstd_pkg::ERR_TOO_LARGE;
                end
                else
                begin
                    res.kind  = pstd_pkg::K_ERROR;
                    res.value = {56'd0, in_byte};
                    res.err   = pstd_pkg::ERR_UNSUPPORTED;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= pstd_pkg::PH_MARKER;
            pending_kind_reg <= pstd_pkg::K_NULL;
            payload_left_reg <= 4'd0;
            string_left_reg  <= 31'd0;
            header_size_reg  <= 4'd0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg        <= phase_next;
                pending_kind_reg <= pending_kind_next;
                payload_left_reg <= payload_left_next;
                string_left_reg  <= string_left_next;
                header_size_reg  <= header_size_next;
            end
            if (skid_valid_reg)
            begin
                if (out_fire)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (produce)
            begin
                if (out_valid_reg && !out_fire)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            acc_reg <= acc_next;
        end
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (produce)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign token_kind  = out_reg.kind;
    assign token_value = $signed(out_reg.value);
    assign struct_tag  = $signed(out_reg.tag);
    assign ends_string = out_reg.ends;
    assign error_code  = out_reg.err;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid register holds a token while the result register is empty.");

    a_string_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == pstd_pkg::PH_STRING |-> string_left_reg != 31'd0)
        else $error("String body phase entered with no bytes left.");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == pstd_pkg::PH_PAYLOAD
        |-> (payload_left_reg != 4'd0 && payload_left_reg <= header_size_reg))
        else $error("Payload byte count out of range.");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (produce && out_valid_reg && out_stall && !skid_valid_reg) |=> skid_valid_reg)
        else $error("Token produced under stall was not buffered.");

    a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_reg.kind == pstd_pkg::K_ERROR)
                           == (out_reg.err != pstd_pkg::ERR_NONE)))
        else $error("Error code does not match token kind.");

endmodule

[tb/tb_packstream_token_decoder.sv]
// Self-checking testbench for packstream_token_decoder: serialized byte streams in, tokens out.
// A built-in token decoder predicts every token, which is checked against the block's output.
// Depends on pstd_pkg and the packstream_token_decoder RTL.
module tb_packstream_token_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import pstd_pkg::*;

    localparam logic [7:0] M_STR16_MARK  = M_STR8 + 8'd1;
    localparam int         RANDOM_BYTES  = 800;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         HOLD_CYCLES   = 80;
    localparam int         DRAIN_CYCLES  = 8;
    localparam int         REPORT_LIMIT  = 10;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         in_byte = 8'h00;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [3:0]         token_kind;
    logic signed [63:0] token_value;
    logic signed [7:0]  struct_tag;
    logic               ends_string;
    logic [1:0]         error_code;

    logic [7:0]  stream_bytes[$];
    result_t     expected_tokens[$];
    int          total_bytes = 0;
    int          bytes_taken = 0;
    int          tokens_taken = 0;
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    logic        in_taken = 1'b0;
    logic        out_taken = 1'b0;
    logic        hold_off = 1'b0;
    int unsigned send_gap = 0;
    int unsigned sent_count = 0;
    int unsigned recv_wait = 0;
    int unsigned recv_count = 0;

    phase_t      dec_phase;
    token_kind_t dec_pending;
    logic [3:0]  dec_pay_left;
    logic [63:0] dec_acc;
    logic [30:0] dec_str_left;
    logic [3:0]  dec_hdr_size;

    packstream_token_decoder uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .token_kind  (token_kind),
        .token_value (token_value),
        .struct_tag  (struct_tag),
        .ends_string (ends_string),
        .error_code  (error_code)
    );

    always #2 clk = ~clk;

    task automatic push_token(token_kind_t k, logic [63:0] v, logic [7:0] t, logic e,
                              error_code_t c);
        result_t r;
        r.kind  = k;
        r.value = v;
        r.tag   = t;
        r.ends  = e;
        r.err   = c;
        expected_tokens.push_back(r);
    endtask

    task automatic open_string(logic [31:0] len);
        if (len == 32'd0) begin
            dec_phase = PH_MARKER;
            push_token(K_STRHDR, 64'd0, 8'd0, 1'b1, ERR_NONE);
        end
        else begin
            dec_phase    = PH_STRING;
            dec_str_left = len[30:0];
            push_token(K_STRHDR, {32'd0, len}, 8'd0, 1'b0, ERR_NONE);
        end
    endtask

    task automatic load_payload(token_kind_t k, logic [3:0] n);
        dec_phase    = PH_PAYLOAD;
        dec_pending  = k;
        dec_pay_left = n;
        dec_hdr_size = n;
        dec_acc      = 64'd0;
    endtask

    task automatic finish_payload();
        logic [63:0] v;
        int          bits;
        v         = dec_acc;
        dec_phase = PH_MARKER;
        if (dec_pending == K_INT) begin
            if (dec_hdr_size >= 4'd1 && dec_hdr_size < 4'd8) begin
                bits = dec_hdr_size * 8;
                if (v[bits-1])
                    v = v | ({64{1'b1}} << bits);
            end
            push_token(K_INT, v, 8'd0, 1'b0, ERR_NONE);
        end
        else if (dec_pending == K_FLOAT) begin
            push_token(K_FLOAT, v, 8'd0, 1'b0, ERR_NONE);
        end
        else if (v[31]) begin
            push_token(K_ERROR, {32'd0, v[31:0]}, 8'd0, 1'b0, ERR_BAD_LENGTH);
        end
        else begin
            open_string(v[31:0]);
        end
    endtask

    task automatic decode_marker(logic [7:0] m);
        if (m < M_TINY_STR)
            push_token(K_INT, {56'd0, m}, 8'd0, 1'b0, ERR_NONE);
        else if (m >= M_NEG_TINY)
            push_token(K_INT, {{56{1'b1}}, m}, 8'd0, 1'b0, ERR_NONE);
        else if (m >= M_INT8 && m <= M_INT64)
            load_payload(K_INT, 4'd1 << (m - M_INT8));
        else if (m < M_TINY_LIST)
            open_string({28'd0, m[3:0]});
        else if (m < M_TINY_MAP)
            push_token(K_LIST, {60'd0, m[3:0]}, 8'd0, 1'b0, ERR_NONE);
        else if (m < M_TINY_STRUCT)
            push_token(K_MAP, {60'd0, m[3:0]}, 8'd0, 1'b0, ERR_NONE);
        else if (m < M_NULL) begin
            dec_phase    = PH_TAG;
            dec_hdr_size = m[3:0];
        end
        else if (m >= M_STR8 && m <= M_STR32)
            load_payload(K_STRHDR, 4'd1 << (m - M_STR8));
        else begin
            case (m)
                M_NULL:    push_token(K_NULL, 64'd0, 8'd0, 1'b0, ERR_NONE);
                M_FLOAT64: load_payload(K_FLOAT, 4'd8);
                M_FALSE:   push_token(K_BOOL, 64'd0, 8'd0, 1'b0, ERR_NONE);
                M_TRUE:    push_token(K_BOOL, 64'd1, 8'd0, 1'b0, ERR_NONE);
                M_LIST8, M_LIST16, M_LIST32, M_MAP8, M_MAP16, M_MAP32,
                M_STRUCT8, M_STRUCT16:
                    push_token(K_ERROR, {56'd0, m}, 8'd0, 1'b0, ERR_TOO_LARGE);
                default:
                    push_token(K_ERROR, {56'd0, m}, 8'd0, 1'b0, ERR_UNSUPPORTED);
            endcase
        end
    endtask

    task automatic decode_byte(logic [7:0] b);
        case (dec_phase)
            PH_PAYLOAD: begin
                dec_acc = {dec_acc[55:0], b};
                if (dec_pay_left != 4'd0)
                    dec_pay_left = dec_pay_left - 4'd1;
                if (dec_pay_left == 4'd0)
                    finish_payload();
            end
            PH_STRING: begin
                if (dec_str_left != 31'd0)
                    dec_str_left = dec_str_left - 31'd1;
                if (dec_str_left == 31'd0) begin
                    dec_phase = PH_MARKER;
                    push_token(K_STRBYTE, {56'd0, b}, 8'd0, 1'b1, ERR_NONE);
                end
                else begin
                    push_token(K_STRBYTE, {56'd0, b}, 8'd0, 1'b0, ERR_NONE);
                end
            end
            PH_TAG: begin
                dec_phase = PH_MARKER;
                push_token(K_STRUCT, {60'd0, dec_hdr_size}, b, 1'b0, ERR_NONE);
            end
            default: decode_marker(b);
        endcase
    endtask

    task automatic check_token();
        result_t want;
        if (expected_tokens.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT)
                $display("unexpected token: kind %0d value %h tag %h ends %b err %0d",
                         token_kind, token_value, struct_tag, ends_string, error_code);
            mismatch_count++;
        end
        else begin
            want = expected_tokens.pop_front();
            if (token_kind !== want.kind || token_value !== want.value ||
                struct_tag !== want.tag || ends_string !== want.ends ||
                error_code !== want.err) begin
                if (mismatch_count < REPORT_LIMIT) begin
                    $display("token mismatch: expected kind %0d value %h tag %h ends %b err %0d",
                             want.kind, want.value, want.tag, want.ends, want.err);
                    $display("                got      kind %0d value %h tag %h ends %b err %0d",
                             token_kind, token_value, struct_tag, ends_string, error_code);
                end
                mismatch_count++;
            end
        end
    endtask

    task automatic queue_byte(logic [7:0] b);
        stream_bytes.push_back(b);
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_payload(int n);
        for (int i = 0; i < n; i++)
            queue_byte(rand_byte());
    endtask

    task automatic queue_random_value();
        int k;
        int len;
        k   = 0;
        len = 0;
        case ($urandom_range(0, 19))
            0, 1: queue_byte(8'($urandom_range(0, 127)));
            2:    queue_byte(8'($urandom_range(240, 255)));
            3:    queue_byte(M_NULL);
            4:    queue_byte($urandom_range(0, 1) ? M_TRUE : M_FALSE);
            5, 6, 7, 18: begin
                k = $urandom_range(0, 3);
                queue_byte(M_INT8 + 8'(k));
                queue_payload(1 << k);
            end
            8: begin
                queue_byte(M_FLOAT64);
                queue_payload(8);
            end
            9, 10: begin
                len = $urandom_range(0, 15);
                queue_byte(M_TINY_STR | 8'(len));
                queue_payload(len);
            end
            11: begin
                len = $urandom_range(0, 20);
                queue_byte(M_STR8);
                queue_byte(8'(len));
                queue_payload(len);
            end
            12: begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(256, 300)
                                                   : $urandom_range(0, 20);
                queue_byte(M_STR16_MARK);
                queue_byte(8'(len >> 8));
                queue_byte(8'(len));
                queue_payload(len);
            end
            13: begin
                queue_byte(M_STR32);
                if ($urandom_range(0, 3) == 0) begin
                    queue_byte(8'h80 | rand_byte());
                    queue_payload(3);
                end
                else begin
                    len = $urandom_range(0, 20);
                    queue_byte(8'h00);
                    queue_byte(8'h00);
                    queue_byte(8'h00);
                    queue_byte(8'(len));
                    queue_payload(len);
                end
            end
            14: queue_byte(8'($urandom_range(144, 175)));
            15: begin
                queue_byte(8'($urandom_range(176, 191)));
                queue_byte(rand_byte());
            end
            16: begin
                case ($urandom_range(0, 7))
                    0: queue_byte(M_LIST8);
                    1: queue_byte(M_LIST16);
                    2: queue_byte(M_LIST32);
                    3: queue_byte(M_MAP8);
                    4: queue_byte(M_MAP16);
                    5: queue_byte(M_MAP32);
                    6: queue_byte(M_STRUCT8);
                    default: queue_byte(M_STRUCT16);
                endcase
            end
            17: queue_byte(8'($urandom_range(196, 239)));
            default: queue_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            dec_phase    = PH_MARKER;
            dec_pending  = K_NULL;
            dec_pay_left = 4'd0;
            dec_acc      = 64'd0;
            dec_str_left = 31'd0;
            dec_hdr_size = 4'd0;
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end
        else begin
            in_taken  <= in_valid && !in_stall;
            out_taken <= out_valid && !out_stall;
            if (out_valid && !out_stall) begin
                check_token();
                tokens_taken++;
            end
            if (in_valid && !in_stall) begin
                decode_byte(in_byte);
                bytes_taken++;
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_byte  <= 8'h00;
            send_gap <= 0;
        end
        else if (in_valid && !in_taken) begin
            in_valid <= 1'b1;
        end
        else if (send_gap != 0) begin
            in_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (stream_bytes.size() != 0) begin
            in_valid <= 1'b1;
            in_byte  <= stream_bytes.pop_front();
            sent_count++;
            send_gap <= sent_count[6] ? 0 : $urandom_range(0, 4);
        end
        else begin
            in_valid <= 1'b0;
        end
    end

    always @(negedge clk) begin : receiver
        int unsigned w;
        if (!rst_n) begin
            out_stall <= 1'b0;
            recv_wait <= 0;
        end
        else if (hold_off) begin
            out_stall <= 1'b1;
        end
        else if (out_taken) begin
            recv_count++;
            w = recv_count[5] ? 0 : $urandom_range(0, 4);
            out_stall <= (w != 0);
            recv_wait <= (w != 0) ? w - 1 : 0;
        end
        else if (recv_wait != 0) begin
            out_stall <= 1'b1;
            recv_wait <= recv_wait - 1;
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    // Long hold on the output so that the buffer fills and the input is stalled.
    initial begin
        wait (tokens_taken >= 150);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        // Tiny integers at both ends of the positive and negative ranges.
        queue_byte(8'h00);
        queue_byte(8'h7F);
        queue_byte(M_NEG_TINY);
        queue_byte(8'hFF);
        queue_byte(M_NULL);
        queue_byte(M_TRUE);
        queue_byte(M_INT8);
        queue_byte(8'h80);
        queue_byte(M_FLOAT64);
        queue_byte(8'h7F);
        queue_byte(8'hF0);
        queue_payload(5);
        queue_byte(8'h01);
        queue_byte(M_TINY_STR | 8'h01);
        queue_byte(8'h41);
        // An empty string has no body.
        queue_byte(M_TINY_STR);
        queue_byte(M_TINY_LIST | 8'h0F);
        queue_byte(M_TINY_MAP);
        queue_byte(M_TINY_STRUCT | 8'h01);
        queue_byte(8'h7F);
        queue_byte(8'hCC);
        queue_byte(M_STRUCT16);
        // A string length with its top bit set is rejected.
        queue_byte(M_STR32);
        queue_byte(8'h80);
        queue_byte(8'h00);
        queue_byte(8'h00);
        queue_byte(8'h00);
        total_bytes = stream_bytes.size() + RANDOM_BYTES;
        while (stream_bytes.size() < total_bytes)
            queue_random_value();
        total_bytes = stream_bytes.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (bytes_taken != total_bytes || expected_tokens.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
